[hdl/mfrla_pkg.sv]
package mfrla_pkg;

    localparam int WINDOW_MAX_DEF = 16;

    localparam int RATE_W    = 10;
    localparam int AGE_W     = 16;
    localparam int WARM_W    = 8;
    localparam int ACT_W     = 5;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 2;

    localparam logic [RATE_W-1:0] LIMIT_MAX    = 10'd1023;
    localparam logic [RATE_W-1:0] BIG_STEP     = 10'd10;
    localparam logic [RATE_W-1:0] GAP_ONE      = 10'd1;
    localparam logic [RATE_W-1:0] TARGET_RESET = 10'd60;
    localparam logic [WARM_W-1:0] WARMUP_RESET = 8'd2;
    localparam logic [ACT_W-1:0]  ACTION_RESET = 5'd5;
    localparam logic [RATE_W-1:0] LIMIT_RESET  = 10'd60;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_ADJUST = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET = 2'd0,
        REG_WARMUP = 2'd1,
        REG_ACTION = 2'd2,
        REG_START  = 2'd3
    } cfg_reg_t;

    // sample memory read address select
    typedef enum logic [1:0] {
        RA_NONE,
        RA_CAND,
        RA_FIRST,
        RA_NEXT
    } ra_sel_t;

    // datapath operation of one control word
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_INIT,
        DP_CAND,
        DP_SCAN,
        DP_CHECK,
        DP_MEDIAN,
        DP_ADJUST,
        DP_RECORD,
        DP_EMIT
    } dp_op_t;

    // jump condition
    typedef enum logic [2:0] {
        JC_ALWAYS,
        JC_NEVER,
        JC_ACCEPT,
        JC_SKIP,
        JC_RECORD,
        JC_SCAN_MORE,
        JC_CAND_MORE,
        JC_OUT_FREE
    } jc_t;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t ST_IDLE    = 4'd0;
    localparam step_t ST_SKIP    = 4'd1;
    localparam step_t ST_BRANCH  = 4'd2;
    localparam step_t ST_CAND_RD = 4'd3;
    localparam step_t ST_CAND    = 4'd4;
    localparam step_t ST_SCAN    = 4'd5;
    localparam step_t ST_CHECK   = 4'd6;
    localparam step_t ST_MEDIAN  = 4'd7;
    localparam step_t ST_ADJUST  = 4'd8;
    localparam step_t ST_RECORD  = 4'd9;
    localparam step_t ST_EMIT    = 4'd10;

    // stall: hold the step when the condition is false instead of advancing
    typedef struct packed {
        ra_sel_t ra;
        dp_op_t  dp;
        jc_t     jc;
        logic    stall;
        step_t   target;
    } ctl_t;

    function automatic ctl_t ucode(input step_t s);
        ctl_t c;
        unique case (s)
            ST_IDLE:    c = '{RA_NONE,  DP_LOAD,   JC_ACCEPT,    1'b1, ST_SKIP};
            ST_SKIP:    c = '{RA_NONE,  DP_INIT,   JC_SKIP,      1'b0, ST_EMIT};
            ST_BRANCH:  c = '{RA_NONE,  DP_NOP,    JC_RECORD,    1'b0, ST_RECORD};
            ST_CAND_RD: c = '{RA_CAND,  DP_NOP,    JC_NEVER,     1'b0, ST_IDLE};
            ST_CAND:    c = '{RA_FIRST, DP_CAND,   JC_NEVER,     1'b0, ST_IDLE};
            ST_SCAN:    c = '{RA_NEXT,  DP_SCAN,   JC_SCAN_MORE, 1'b0, ST_SCAN};
            ST_CHECK:   c = '{RA_NONE,  DP_CHECK,  JC_CAND_MORE, 1'b0, ST_CAND_RD};
            ST_MEDIAN:  c = '{RA_NONE,  DP_MEDIAN, JC_NEVER,     1'b0, ST_IDLE};
            ST_ADJUST:  c = '{RA_NONE,  DP_ADJUST, JC_ALWAYS,    1'b0, ST_EMIT};
            ST_RECORD:  c = '{RA_NONE,  DP_RECORD, JC_NEVER,     1'b0, ST_IDLE};
            ST_EMIT:    c = '{RA_NONE,  DP_EMIT,   JC_OUT_FREE,  1'b1, ST_IDLE};
            default:    c = '{RA_NONE,  DP_NOP,    JC_ALWAYS,    1'b0, ST_IDLE};
        endcase
        return c;
    endfunction

endpackage

[hdl/mfrla_if.sv]
interface mfrla_in_if;
    logic                           valid;
    logic                           ready;
    logic                           op;
    logic [mfrla_pkg::RATE_W-1:0]   frame_count;
    logic [mfrla_pkg::AGE_W-1:0]    age_seconds;

    modport source (output valid, op, frame_count, age_seconds, input ready);
    modport sink   (input valid, op, frame_count, age_seconds, output ready);
endinterface

interface mfrla_out_if;
    logic                           valid;
    logic                           ready;
    logic [mfrla_pkg::RATE_W-1:0]   rate_limit;
    logic                           limit_applied;
    logic                           window_cleared;
    logic [mfrla_pkg::RATE_W-1:0]   median_rate;

    modport source (output valid, rate_limit, limit_applied, window_cleared, median_rate,
                    input ready);
    modport sink   (input valid, rate_limit, limit_applied, window_cleared, median_rate,
                    output ready);
endinterface

[hdl/median_frame_rate_limit_adjust_top.sv]
// Median frame rate limit adjuster. Each input word is a record (append frame_count to a
// window of the last WINDOW_MAX samples) or an adjust (take the window median, compare it
// with target_rate and step the active rate limit by the gap when it is 2 to 9, by 10 when
// it exceeds 10 and not at all for a gap of 0, 1 or 10, saturating at 0 and 1023); both
// do nothing while age_seconds is below warmup_seconds. Every input word yields exactly
// one output word. A skipped item goes from ST_SKIP straight to ST_EMIT, a record passes
// ST_SKIP, ST_BRANCH, ST_RECORD and ST_EMIT. An adjust that passes the warm-up and sample
// count checks scans candidates until both middle ranks are found, whether or not it then
// moves the limit: the median is found by rank counting, each candidate sample compared
// against every sample through the single read port of the sample memory, one sample per
// cycle. A new word is taken once the previous result has been loaded into the output
// register. Writing start_limit loads the active limit at once.
module median_frame_rate_limit_adjust_top #(
    parameter int WINDOW_MAX = mfrla_pkg::WINDOW_MAX_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    mfrla_in_if.sink                          in_ch,
    mfrla_out_if.source                       out_ch,
    input  logic                              cfg_we,
    input  logic [mfrla_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mfrla_pkg::CFG_W-1:0]       cfg_data
);
    import mfrla_pkg::*;

    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int CMP_W = (CNT_W > ACT_W) ? CNT_W : ACT_W;
    localparam logic [CNT_W-1:0] FILL_FULL = CNT_W'(WINDOW_MAX);
    localparam logic [IDX_W-1:0] HEAD_LAST = IDX_W'(WINDOW_MAX - 1);

    // configuration
    logic [RATE_W-1:0] target_reg;
    logic [WARM_W-1:0] warmup_reg;
    logic [ACT_W-1:0]  action_reg;

    // sequencer
    step_t step_reg;
    step_t step_next;
    ctl_t  ctl;
    logic  jump;

    // latched input word
    logic              op_reg;
    logic [RATE_W-1:0] frame_reg;
    logic [AGE_W-1:0]  age_reg;

    // window state
    logic [RATE_W-1:0] mem [WINDOW_MAX];
    logic [RATE_W-1:0] rdata_reg;
    logic [IDX_W-1:0]  raddr;
    logic [IDX_W-1:0]  waddr;
    logic              mem_we;
    logic [CNT_W-1:0]  fill_reg;
    logic [IDX_W-1:0]  head_reg;
    logic [RATE_W-1:0] limit_reg;

    // median selection
    logic [CNT_W-1:0]  i_reg;
    logic [CNT_W-1:0]  j_reg;
    logic [CNT_W-1:0]  lt_reg;
    logic [CNT_W-1:0]  le_reg;
    logic [RATE_W-1:0] cand_reg;
    logic [RATE_W-1:0] lo_val_reg;
    logic [RATE_W-1:0] hi_val_reg;
    logic              lo_found_reg;
    logic              hi_found_reg;
    logic [CNT_W-1:0]  j_inc;
    logic [CNT_W-1:0]  half;
    logic [CNT_W-1:0]  k_lo;
    logic              lo_hit;
    logic              hi_hit;
    logic              scan_more;
    logic              cand_more;
    logic [RATE_W:0]   med_sum;

    // result
    logic [RATE_W-1:0] med_reg;
    logic              applied_reg;
    logic              cleared_reg;

    // adjust datapath
    logic              below;
    logic              above;
    logic [RATE_W-1:0] gap;
    logic [RATE_W-1:0] step_amt;
    logic [RATE_W:0]   up_sum;
    logic [RATE_W-1:0] up_lim;
    logic [RATE_W-1:0] dn_lim;
    logic              adj_act;

    // handshake
    logic accept_in;
    logic out_free;
    logic skip;

    // output register
    logic              ovalid_reg;
    logic [RATE_W-1:0] out_limit_reg;
    logic              out_applied_reg;
    logic              out_cleared_reg;
    logic [RATE_W-1:0] out_med_reg;

    assign ctl       = ucode(step_reg);
    assign in_ch.ready = (step_reg == ST_IDLE);
    assign accept_in = in_ch.valid && in_ch.ready;
    assign out_free  = !ovalid_reg || out_ch.ready;

    assign out_ch.valid          = ovalid_reg;
    assign out_ch.rate_limit     = out_limit_reg;
    assign out_ch.limit_applied  = out_applied_reg;
    assign out_ch.window_cleared = out_cleared_reg;
    assign out_ch.median_rate    = out_med_reg;

    assign skip = (age_reg < AGE_W'(warmup_reg))
               || ((op_reg == OP_ADJUST)
                   && ((fill_reg == '0) || (CMP_W'(fill_reg) < CMP_W'(action_reg))));

    // rank bookkeeping: lower and upper middle ranks coincide for an odd count
    assign j_inc     = j_reg + 1'b1;
    assign scan_more = j_inc < fill_reg;
    assign half      = fill_reg >> 1;
    assign k_lo      = fill_reg[0] ? half : half - 1'b1;
    assign lo_hit    = (lt_reg <= k_lo) && (k_lo < le_reg);
    assign hi_hit    = (lt_reg <= half) && (half < le_reg);
    assign cand_more = !((lo_found_reg || lo_hit) && (hi_found_reg || hi_hit));
    assign med_sum   = {1'b0, lo_val_reg} + {1'b0, hi_val_reg};

    assign below    = med_reg < target_reg;
    assign above    = med_reg > target_reg;
    assign gap      = below ? (target_reg - med_reg) : (med_reg - target_reg);
    assign step_amt = (gap > BIG_STEP) ? BIG_STEP
                    : ((gap > GAP_ONE) && (gap < BIG_STEP)) ? gap : '0;
    assign up_sum   = {1'b0, limit_reg} + {1'b0, step_amt};
    assign up_lim   = (up_sum > {1'b0, LIMIT_MAX}) ? LIMIT_MAX : up_sum[RATE_W-1:0];
    assign dn_lim   = (limit_reg > step_amt) ? (limit_reg - step_amt) : '0;
    assign adj_act  = below || (above && (gap != GAP_ONE));

    assign mem_we = (ctl.dp == DP_RECORD);
    assign waddr  = (fill_reg < FILL_FULL) ? fill_reg[IDX_W-1:0] : head_reg;

    always_comb
    begin
        unique case (ctl.ra)
            RA_CAND:  raddr = i_reg[IDX_W-1:0];
            RA_NEXT:  raddr = scan_more ? j_inc[IDX_W-1:0] : '0;
            RA_FIRST: raddr = '0;
            RA_NONE:  raddr = '0;
            default:  raddr = '0;
        endcase
    end

    always_comb
    begin
        unique case (ctl.jc)
            JC_ALWAYS:    jump = 1'b1;
            JC_NEVER:     jump = 1'b0;
            JC_ACCEPT:    jump = accept_in;
            JC_SKIP:      jump = skip;
            JC_RECORD:    jump = (op_reg == OP_RECORD);
            JC_SCAN_MORE: jump = scan_more;
            JC_CAND_MORE: jump = cand_more;
            JC_OUT_FREE:  jump = out_free;
            default:      jump = 1'b0;
        endcase
    end

    always_comb
    begin
        if (jump)
        begin
            step_next = ctl.target;
        end
        else if (ctl.stall)
        begin
            step_next = step_reg;
        end
        else
        begin
            step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= frame_reg;
        end
        rdata_reg <= mem[raddr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= ST_IDLE;
            target_reg   <= TARGET_RESET;
            warmup_reg   <= WARMUP_RESET;
            action_reg   <= ACTION_RESET;
            limit_reg    <= LIMIT_RESET;
            fill_reg     <= '0;
            head_reg     <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            lt_reg       <= '0;
            le_reg       <= '0;
            lo_found_reg <= 1'b0;
            hi_found_reg <= 1'b0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;

            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_TARGET: target_reg <= cfg_data;
                    REG_WARMUP: warmup_reg <= cfg_data[WARM_W-1:0];
                    REG_ACTION: action_reg <= cfg_data[ACT_W-1:0];
                    REG_START:  limit_reg  <= cfg_data;
                    default:    ;
                endcase
            end

            unique case (ctl.dp)
                DP_INIT:
                begin
                    i_reg        <= '0;
                    lo_found_reg <= 1'b0;
                    hi_found_reg <= 1'b0;
                end
                DP_CAND:
                begin
                    j_reg  <= '0;
                    lt_reg <= '0;
                    le_reg <= '0;
                end
                DP_SCAN:
                begin
                    j_reg  <= j_inc;
                    lt_reg <= lt_reg + CNT_W'(rdata_reg < cand_reg);
                    le_reg <= le_reg + CNT_W'(rdata_reg <= cand_reg);
                end
                DP_CHECK:
                begin
                    i_reg <= i_reg + 1'b1;
                    if (lo_hit)
                    begin
                        lo_found_reg <= 1'b1;
                    end
                    if (hi_hit)
                    begin
                        hi_found_reg <= 1'b1;
                    end
                end
                DP_ADJUST:
                begin
                    if (below)
                    begin
                        limit_reg <= up_lim;
                    end
                    else if (above)
                    begin
                        limit_reg <= dn_lim;
                    end
                    if (adj_act)
                    begin
                        fill_reg <= '0;
                        head_reg <= '0;
                    end
                end
                DP_RECORD:
                begin
                    if (fill_reg < FILL_FULL)
                    begin
                        fill_reg <= fill_reg + 1'b1;
                    end
                    else
                    begin
                        head_reg <= (head_reg == HEAD_LAST) ? '0 : head_reg + 1'b1;
                    end
                end
                default: ;
            endcase

            // hold the result word until taken
            if ((ctl.dp == DP_EMIT) && out_free)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if ((ctl.dp == DP_LOAD) && accept_in)
        begin
            op_reg    <= in_ch.op;
            frame_reg <= in_ch.frame_count;
            age_reg   <= in_ch.age_seconds;
        end
        if (ctl.dp == DP_INIT)
        begin
            med_reg     <= '0;
            applied_reg <= 1'b0;
            cleared_reg <= 1'b0;
        end
        if (ctl.dp == DP_CAND)
        begin
            cand_reg <= rdata_reg;
        end
        if ((ctl.dp == DP_CHECK) && lo_hit)
        begin
            lo_val_reg <= cand_reg;
        end
        if ((ctl.dp == DP_CHECK) && hi_hit)
        begin
            hi_val_reg <= cand_reg;
        end
        if (ctl.dp == DP_MEDIAN)
        begin
            med_reg <= med_sum[RATE_W:1];
        end
        if (ctl.dp == DP_ADJUST)
        begin
            applied_reg <= adj_act;
            cleared_reg <= adj_act;
        end
        if ((ctl.dp == DP_EMIT) && out_free)
        begin
            out_limit_reg   <= limit_reg;
            out_applied_reg <= applied_reg;
            out_cleared_reg <= cleared_reg;
            out_med_reg     <= med_reg;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_FULL)
        else $error("window fill beyond capacity");

    a_head_full: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg != '0) |-> (fill_reg == FILL_FULL))
        else $error("window head moved before window filled");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.dp == DP_SCAN) |-> (j_reg < fill_reg))
        else $error("scan past last sample");

    a_median_found: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.dp == DP_MEDIAN) |-> (lo_found_reg && hi_found_reg))
        else $error("median taken before both middle ranks found");

    a_clear_emit: assert property (@(posedge clk) disable iff (!rst_n)
        ((ctl.dp == DP_EMIT) && cleared_reg) |-> ((fill_reg == '0) && (head_reg == '0)))
        else $error("window reported cleared but still holds samples");

endmodule
